@@ rtl/zcrd_pkg.sv @@
// shared types, widths and constants of the zebra crossing row detector
package zcrd_pkg;

   localparam int COLUMN_BITS_DEFAULT = 8;

   localparam int GRAY_BITS      = 8;
   localparam int STEP_BITS      = 8;
   localparam int CONTRAST_BITS  = 9;
   localparam int PERCENT_BITS   = 7;
   localparam int ROW_BITS       = 8;
   localparam int CSR_DATA_BITS  = 9;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [STEP_BITS-1:0]     STEP_MAX     = '1;
   localparam logic [CONTRAST_BITS-1:0] CONTRAST_MAX = '1;
   localparam logic [PERCENT_BITS-1:0]  PERCENT_SCALE = 7'd100;

   localparam logic [STEP_BITS-1:0]     STEP_THRESHOLD_RESET     = 8'd5;
   localparam logic [PERCENT_BITS-1:0]  CONTRAST_PERCENT_RESET   = 7'd12;
   localparam logic [CONTRAST_BITS-1:0] COMBINED_THRESHOLD_RESET = 9'd25;
   localparam logic [ROW_BITS-1:0]      GATE_ROW_RESET           = 8'd50;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_STEP_THRESHOLD     = 2'd0,
      REG_CONTRAST_PERCENT   = 2'd1,
      REG_COMBINED_THRESHOLD = 2'd2,
      REG_GATE_ROW           = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]     step_threshold;
      logic [PERCENT_BITS-1:0]  contrast_percent;
      logic [CONTRAST_BITS-1:0] combined_threshold;
      logic [ROW_BITS-1:0]      gate_row;
   } cfg_type;

   // per pixel decisions handed from evaluation to the row judge
   typedef struct packed {
      logic step_inc;
      logic contrast_inc;
      logic row_end;
      logic frame_end;
      logic gate_ok;
   } flags_type;

endpackage

@@ rtl/zcrd_pixel_eval.sv @@
// request register and per pixel evaluation of binary and gray steps
module zcrd_pixel_eval
   import zcrd_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COLUMN_BITS-1:0] req_column,
   input  logic [COLUMN_BITS-1:0] req_left_border,
   input  logic [COLUMN_BITS-1:0] req_right_border,
   input  logic                   req_bin_here,
   input  logic                   req_bin_right,
   input  logic [GRAY_BITS-1:0]   req_gray_here,
   input  logic [GRAY_BITS-1:0]   req_gray_two_left,
   input  logic                   req_row_end,
   input  logic                   req_frame_end,
   input  logic [ROW_BITS-1:0]    req_reach_height,
   input  logic [ROW_BITS-1:0]    req_top_row,
   output logic                   flags_valid,
   output flags_type              flags,
   input  logic                   flags_take
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [COLUMN_BITS-1:0] column_ff, left_ff, right_ff;
   logic                   bin_here_ff, bin_right_ff;
   logic [GRAY_BITS-1:0]   gray_here_ff, gray_left_ff;
   logic                   row_end_ff, frame_end_ff;
   logic [ROW_BITS-1:0]    reach_ff, top_ff;

   logic      s2_valid_ff, s2_valid_in;
   flags_type flags_ff, flags_in;

   logic s1_free, s2_free;

   logic                 in_track;
   logic [GRAY_BITS:0]   gray_sum;
   logic [GRAY_BITS-1:0] gray_diff;
   logic [14:0]          diff_scaled;
   logic [16:0]          sum_scaled;

   assign s2_free   = !s2_valid_ff || flags_take;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   assign s1_valid_in = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      in_track  = (column_ff >= left_ff) && (column_ff < right_ff);
      gray_sum  = {1'b0, gray_here_ff} + {1'b0, gray_left_ff};
      gray_diff = (gray_here_ff >= gray_left_ff) ? (gray_here_ff - gray_left_ff)
                                                 : (gray_left_ff - gray_here_ff);
      diff_scaled = 15'(gray_diff) * 15'(PERCENT_SCALE);
      sum_scaled  = (17'(cfg.contrast_percent) + 17'd1) * 17'(gray_sum);

      flags_in.step_inc     = in_track && !bin_here_ff && bin_right_ff;
      // columns zero and one have no pixel two to the left
      flags_in.contrast_inc = in_track && (column_ff[COLUMN_BITS-1:1] != '0)
                              && (gray_sum != '0)
                              && ({2'b00, diff_scaled} >= sum_scaled);
      flags_in.row_end      = row_end_ff;
      flags_in.frame_end    = frame_end_ff;
      flags_in.gate_ok      = (reach_ff >= cfg.gate_row) && (top_ff >= cfg.gate_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_free && req_valid) begin
         column_ff    <= req_column;
         left_ff      <= req_left_border;
         right_ff     <= req_right_border;
         bin_here_ff  <= req_bin_here;
         bin_right_ff <= req_bin_right;
         gray_here_ff <= req_gray_here;
         gray_left_ff <= req_gray_two_left;
         row_end_ff   <= req_row_end;
         frame_end_ff <= req_frame_end;
         reach_ff     <= req_reach_height;
         top_ff       <= req_top_row;
      end
      if (s2_free && s1_valid_ff) begin
         flags_ff <= flags_in;
      end
   end

   assign flags_valid = s2_valid_ff;
   assign flags       = flags_ff;

endmodule

@@ rtl/zcrd_row_judge.sv @@
// step counters, row judgement, frame hit and result register
module zcrd_row_judge
   import zcrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      flags_valid,
   input  flags_type flags,
   output logic      flags_take,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic      rsp_crossing_found
);

   logic [STEP_BITS-1:0]     step_ff, step_in, step_next;
   logic [CONTRAST_BITS-1:0] contrast_ff, contrast_in, contrast_next;
   logic                     hit_ff, hit_in, hit_next;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic                     out_free, row_done;
   logic [CONTRAST_BITS:0]   combined;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // a frame end request needs the result slot, anything else passes
   assign flags_take = flags_valid && (!flags.frame_end || out_free);

   always_comb begin
      step_next = step_ff;
      if (flags.step_inc && step_ff != STEP_MAX) begin
         step_next = step_ff + 1'b1;
      end
      contrast_next = contrast_ff;
      if (flags.contrast_inc && contrast_ff != CONTRAST_MAX) begin
         contrast_next = contrast_ff + 1'b1;
      end
      combined = {2'b00, step_next} + {1'b0, contrast_next};
      row_done = flags.row_end || flags.frame_end;

      hit_next = hit_ff;
      if (row_done) begin
         if (step_next > cfg.step_threshold) begin
            hit_next = 1'b1;
         end else if (step_next == cfg.step_threshold
                      && combined > {1'b0, cfg.combined_threshold}) begin
            hit_next = 1'b1;
         end
      end

      step_in      = step_ff;
      contrast_in  = contrast_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (flags_take) begin
         step_in     = row_done ? '0 : step_next;
         contrast_in = row_done ? '0 : contrast_next;
         hit_in      = flags.frame_end ? 1'b0 : hit_next;
         if (flags.frame_end) begin
            found_in     = hit_next && flags.gate_ok;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         contrast_ff  <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         contrast_ff  <= contrast_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff <= found_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_crossing_found = found_ff;

endmodule

@@ rtl/zebra_crossing_row_detector.sv @@
// top level: control registers, pixel evaluation and row judgement
// a frame end request passes the request register and the flag register, then loads the result register
// throughput: one request per cycle while req_stall is low; the request register,
//   the flag register and the result register form a three deep stalling pipeline
// a request is held back only while a frame result waits to be taken
// reset: synchronous, clears counters, hit, valids and loads register defaults
module zebra_crossing_row_detector
   import zcrd_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COLUMN_BITS-1:0]    req_column,
   input  logic [COLUMN_BITS-1:0]    req_left_border,
   input  logic [COLUMN_BITS-1:0]    req_right_border,
   input  logic                      req_bin_here,
   input  logic                      req_bin_right,
   input  logic [GRAY_BITS-1:0]      req_gray_here,
   input  logic [GRAY_BITS-1:0]      req_gray_two_left,
   input  logic                      req_row_end,
   input  logic                      req_frame_end,
   input  logic [ROW_BITS-1:0]       req_reach_height,
   input  logic [ROW_BITS-1:0]       req_top_row,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_crossing_found
);

   cfg_type   cfg_ff, cfg_in;
   logic      flags_valid, flags_take;
   flags_type flags;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_STEP_THRESHOLD:     cfg_in.step_threshold = csr_write_data[STEP_BITS-1:0];
            REG_CONTRAST_PERCENT:   cfg_in.contrast_percent =
                                       csr_write_data[PERCENT_BITS-1:0];
            REG_COMBINED_THRESHOLD: cfg_in.combined_threshold =
                                       csr_write_data[CONTRAST_BITS-1:0];
            REG_GATE_ROW:           cfg_in.gate_row = csr_write_data[ROW_BITS-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_threshold     <= STEP_THRESHOLD_RESET;
         cfg_ff.contrast_percent   <= CONTRAST_PERCENT_RESET;
         cfg_ff.combined_threshold <= COMBINED_THRESHOLD_RESET;
         cfg_ff.gate_row           <= GATE_ROW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   zcrd_pixel_eval #(
      .COLUMN_BITS(COLUMN_BITS)
   ) u_eval (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_column        (req_column),
      .req_left_border   (req_left_border),
      .req_right_border  (req_right_border),
      .req_bin_here      (req_bin_here),
      .req_bin_right     (req_bin_right),
      .req_gray_here     (req_gray_here),
      .req_gray_two_left (req_gray_two_left),
      .req_row_end       (req_row_end),
      .req_frame_end     (req_frame_end),
      .req_reach_height  (req_reach_height),
      .req_top_row       (req_top_row),
      .flags_valid       (flags_valid),
      .flags             (flags),
      .flags_take        (flags_take)
   );

   zcrd_row_judge u_judge (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .flags_valid        (flags_valid),
      .flags              (flags),
      .flags_take         (flags_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crossing_found (rsp_crossing_found)
   );

endmodule

@@ rtl/zcrd_checker.sv @@
// port level assertions for the zebra crossing row detector and their binding
module zcrd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_frame_end,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_crossing_found
);

   // a waiting result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crossing_found))
      else $error("stalled response changed");

   // requests are only held back behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a frame end request loads the response register when not held up
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_frame_end) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("frame result missing");

endmodule

bind zebra_crossing_row_detector zcrd_checker u_zcrd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_frame_end      (req_frame_end),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_crossing_found (rsp_crossing_found)
);

@@ dv/zebra_crossing_row_detector_tb.sv @@
// testbench of the zebra crossing row detector: directed table, random frames, predictor check
module zebra_crossing_row_detector_tb
   import zcrd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COL_W          = COLUMN_BITS_DEFAULT;
   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HAMMER_LEN     = 520;
   localparam int PHASE_REQUESTS = 160;
   localparam int REPORT_LIMIT   = 10;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [COL_W-1:0]     column;
      logic [COL_W-1:0]     left_border;
      logic [COL_W-1:0]     right_border;
      logic                 bin_here;
      logic                 bin_right;
      logic [GRAY_BITS-1:0] gray_here;
      logic [GRAY_BITS-1:0] gray_two_left;
      logic                 row_end;
      logic                 frame_end;
      logic [ROW_BITS-1:0]  reach_height;
      logic [ROW_BITS-1:0]  top_row;
   } pixel_type;

   typedef struct packed {
      pixel_type px;
      logic      fixed;
      logic      found;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_STEP_THRESHOLD;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [COL_W-1:0]          req_column = '0;
   logic [COL_W-1:0]          req_left_border = '0;
   logic [COL_W-1:0]          req_right_border = '0;
   logic                      req_bin_here = 1'b0;
   logic                      req_bin_right = 1'b0;
   logic [GRAY_BITS-1:0]      req_gray_here = '0;
   logic [GRAY_BITS-1:0]      req_gray_two_left = '0;
   logic                      req_row_end = 1'b0;
   logic                      req_frame_end = 1'b0;
   logic [ROW_BITS-1:0]       req_reach_height = '0;
   logic [ROW_BITS-1:0]       req_top_row = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_crossing_found;

   // predictor copy of the control registers and of the row state
   cfg_type                  csr_shadow = '{
      step_threshold:     STEP_THRESHOLD_RESET,
      contrast_percent:   CONTRAST_PERCENT_RESET,
      combined_threshold: COMBINED_THRESHOLD_RESET,
      gate_row:           GATE_ROW_RESET
   };
   logic [STEP_BITS-1:0]     step_tally = '0;
   logic [CONTRAST_BITS-1:0] contrast_tally = '0;
   logic                     frame_hit = 1'b0;

   logic             crossing_q[$];
   directed_row_type directed_rows[$];
   logic             wanted;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               pixels_sent = 0;
   int               failures = 0;
   int unsigned      cycle_count = 0;

   zebra_crossing_row_detector uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_column         (req_column),
      .req_left_border    (req_left_border),
      .req_right_border   (req_right_border),
      .req_bin_here       (req_bin_here),
      .req_bin_right      (req_bin_right),
      .req_gray_here      (req_gray_here),
      .req_gray_two_left  (req_gray_two_left),
      .req_row_end        (req_row_end),
      .req_frame_end      (req_frame_end),
      .req_reach_height   (req_reach_height),
      .req_top_row        (req_top_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_crossing_found (rsp_crossing_found)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic pixel_type pix(int col, int lb, int rb, int bh, int br, int gh, int g2,
                                     int re, int fe, int reach, int top);
      pixel_type p;
      p.column        = COL_W'(col);
      p.left_border   = COL_W'(lb);
      p.right_border  = COL_W'(rb);
      p.bin_here      = 1'(bh);
      p.bin_right     = 1'(br);
      p.gray_here     = GRAY_BITS'(gh);
      p.gray_two_left = GRAY_BITS'(g2);
      p.row_end       = 1'(re);
      p.frame_end     = 1'(fe);
      p.reach_height  = ROW_BITS'(reach);
      p.top_row       = ROW_BITS'(top);
      return p;
   endfunction

   function automatic cfg_type mk_cfg(int thr, int pct, int comb, int gate);
      cfg_type c;
      c.step_threshold     = STEP_BITS'(thr);
      c.contrast_percent   = PERCENT_BITS'(pct);
      c.combined_threshold = CONTRAST_BITS'(comb);
      c.gate_row           = ROW_BITS'(gate);
      return c;
   endfunction

   // division free ratio test, a zero sum never counts
   function automatic logic contrast_seen(logic [GRAY_BITS-1:0] a, logic [GRAY_BITS-1:0] b);
      int unsigned sum;
      int unsigned diff;
      sum  = a + b;
      diff = (a >= b) ? a - b : b - a;
      if (sum == 0)
         return 1'b0;
      return diff * PERCENT_SCALE >= (csr_shadow.contrast_percent + 1) * sum;
   endfunction

   task automatic predict_crossing(input pixel_type p, output logic made, output logic found);
      made  = 1'b0;
      found = 1'b0;
      if (p.column >= p.left_border && p.column < p.right_border) begin
         if (!p.bin_here && p.bin_right && step_tally != STEP_MAX)
            step_tally++;
         if (p.column >= 2 && contrast_seen(p.gray_here, p.gray_two_left) &&
             contrast_tally != CONTRAST_MAX)
            contrast_tally++;
      end
      if (p.row_end || p.frame_end) begin
         if (step_tally > csr_shadow.step_threshold)
            frame_hit = 1'b1;
         else if (step_tally == csr_shadow.step_threshold &&
                  int'(step_tally) + int'(contrast_tally) > int'(csr_shadow.combined_threshold))
            frame_hit = 1'b1;
         step_tally     = '0;
         contrast_tally = '0;
      end
      if (p.frame_end) begin
         made      = 1'b1;
         found     = frame_hit && p.reach_height >= csr_shadow.gate_row &&
                     p.top_row >= csr_shadow.gate_row;
         frame_hit = 1'b0;
      end
   endtask

   task automatic send_pixel(input pixel_type p, input logic fixed, input logic fixed_found);
      logic made;
      logic found;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_column        <= p.column;
      req_left_border   <= p.left_border;
      req_right_border  <= p.right_border;
      req_bin_here      <= p.bin_here;
      req_bin_right     <= p.bin_right;
      req_gray_here     <= p.gray_here;
      req_gray_two_left <= p.gray_two_left;
      req_row_end       <= p.row_end;
      req_frame_end     <= p.frame_end;
      req_reach_height  <= p.reach_height;
      req_top_row       <= p.top_row;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_crossing(p, made, found);
      if (made)
         crossing_q.push_back(fixed ? fixed_found : found);
      pixels_sent++;
   endtask

   // upper data bits beyond a register's width are filled with junk
   task automatic load_settings(input cfg_type c);
      reg_index_type            idx;
      logic [CSR_DATA_BITS-1:0] data;
      for (int i = REG_STEP_THRESHOLD; i <= REG_GATE_ROW; i++) begin
         idx = reg_index_type'(i);
         case (idx)
            REG_STEP_THRESHOLD: begin
               data = CSR_DATA_BITS'(c.step_threshold) |
                      (CSR_DATA_BITS'($urandom_range(0, 1)) << STEP_BITS);
            end
            REG_CONTRAST_PERCENT: begin
               data = CSR_DATA_BITS'(c.contrast_percent) |
                      (CSR_DATA_BITS'($urandom_range(0, 3)) << PERCENT_BITS);
            end
            REG_COMBINED_THRESHOLD: begin
               data = c.combined_threshold;
            end
            default: begin
               data = CSR_DATA_BITS'(c.gate_row) |
                      (CSR_DATA_BITS'($urandom_range(0, 1)) << ROW_BITS);
            end
         endcase
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= data;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      csr_shadow = c;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (crossing_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ROW_BITS-1:0] near_gate();
      case ($urandom_range(0, 3))
         0: return csr_shadow.gate_row;
         1: return csr_shadow.gate_row - 1'b1;
         2: return '1;
         default: return ROW_BITS'($urandom);
      endcase
   endfunction

   // one to three rows over a narrow stretch of columns, last column closes the frame
   task automatic send_frame();
      int        rows;
      int        width;
      int        first;
      int        step_pct;
      int        other;
      logic [COL_W-1:0] lb;
      logic [COL_W-1:0] rb;
      pixel_type p;
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
         width    = $urandom_range(1, 24);
         first    = $urandom_range(0, 255 - width);
         step_pct = $urandom_range(0, 60);
         lb = COL_W'(first + $urandom_range(0, 3));
         rb = COL_W'(first + width - $urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) begin
            lb = COL_W'($urandom);
            rb = COL_W'($urandom);
         end
         for (int i = 0; i < width; i++) begin
            p              = pixel_type'($urandom);
            p.column       = COL_W'(first + i);
            p.left_border  = lb;
            p.right_border = rb;
            if ($urandom_range(0, 99) < step_pct)
               {p.bin_here, p.bin_right} = 2'b01;
            else
               {p.bin_here, p.bin_right} = 2'($urandom);
            p.gray_here = GRAY_BITS'($urandom);
            case ($urandom_range(0, 3))
               0: p.gray_two_left = GRAY_BITS'($urandom);
               1: begin
                  other = int'(p.gray_here) + $urandom_range(0, 60) - 30;
                  if (other < 0)
                     other = 0;
                  if (other > 255)
                     other = 255;
                  p.gray_two_left = GRAY_BITS'(other);
               end
               2: begin
                  p.gray_here     = ($urandom_range(0, 1) == 0) ? '0 : p.gray_here;
                  p.gray_two_left = '0;
               end
               default: p.gray_two_left = p.gray_here;
            endcase
            p.row_end   = (i == width - 1);
            p.frame_end = (i == width - 1) && (r == rows - 1);
            if (p.frame_end) begin
               p.row_end      = 1'($urandom);
               p.reach_height = near_gate();
               p.top_row      = near_gate();
            end
            send_pixel(p, 1'b0, 1'b0);
         end
      end
   endtask

   task automatic run_phase(input cfg_type c, input int idle, input int stall, input int count,
                            input logic with_hammer);
      int        goal;
      pixel_type p;
      send_idle_pct = idle;
      stall_pct     = stall;
      load_settings(c);
      // saturates both counters in one row, a wrapping counter would miss the hit
      if (with_hammer) begin
         for (int i = 0; i < HAMMER_LEN; i++)
            send_pixel(pix(10, 0, 255, 0, 1, 255, 0, 0, i == HAMMER_LEN - 1, 0, 0),
                       1'b0, 1'b0);
      end
      goal = pixels_sent + count;
      while (pixels_sent < goal) begin
         if ($urandom_range(0, 5) == 0) begin
            p           = pixel_type'({$urandom, $urandom, $urandom});
            p.row_end   = ($urandom_range(0, 7) == 0);
            p.frame_end = ($urandom_range(0, 15) == 0);
            send_pixel(p, 1'b0, 1'b0);
         end else begin
            send_frame();
         end
      end
      settle();
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (crossing_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected frame result crossing_found=%0b", rsp_crossing_found);
         end else begin
            wanted = crossing_q.pop_front();
            if (rsp_crossing_found !== wanted) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("crossing_found mismatch: expected %0b actual %0b",
                           wanted, rsp_crossing_found);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[zebra_crossing_row_detector] ERROR");
         $finish;
      end
   end

   initial begin
      // row: column, borders, bins, grays, row end, frame end, reach, top
      directed_rows.push_back('{pix(0, 0, 0, 0, 0, 0, 0, 0, 1, 255, 255), 1'b1, 1'b0});
      directed_rows.push_back('{pix(0, 0, 255, 0, 1, 9, 9, 0, 0, 50, 50), 1'b0, 1'b0});
      directed_rows.push_back('{pix(1, 0, 255, 0, 1, 9, 9, 0, 0, 50, 50), 1'b0, 1'b0});
      directed_rows.push_back('{pix(2, 0, 255, 0, 1, 9, 9, 0, 0, 50, 50), 1'b0, 1'b0});
      directed_rows.push_back('{pix(3, 0, 255, 0, 1, 9, 9, 0, 0, 50, 50), 1'b0, 1'b0});
      directed_rows.push_back('{pix(4, 0, 255, 0, 1, 9, 9, 0, 0, 50, 50), 1'b0, 1'b0});
      directed_rows.push_back('{pix(5, 0, 255, 0, 1, 9, 9, 0, 1, 50, 50), 1'b1, 1'b1});
      directed_rows.push_back('{pix(10, 0, 255, 0, 1, 9, 9, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(11, 0, 255, 0, 1, 9, 9, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(12, 0, 255, 0, 1, 9, 9, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(13, 0, 255, 0, 1, 9, 9, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(14, 0, 255, 0, 1, 9, 9, 0, 0, 0, 0), 1'b0, 1'b0});
      // six steps but the top row misses the gate
      directed_rows.push_back('{pix(15, 0, 255, 0, 1, 9, 9, 0, 1, 255, 49), 1'b1, 1'b0});
      // inverted borders, left edge, zero gray sum, exclusive right border
      directed_rows.push_back('{pix(150, 200, 100, 0, 1, 255, 0, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(1, 0, 255, 1, 1, 255, 0, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(2, 0, 255, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(255, 0, 255, 0, 1, 0, 255, 0, 0, 255, 255), 1'b0, 1'b0});
      directed_rows.push_back('{pix(7, 7, 8, 0, 1, 200, 10, 0, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(254, 0, 255, 0, 1, 255, 255, 1, 0, 0, 0), 1'b0, 1'b0});
      directed_rows.push_back('{pix(0, 0, 0, 1, 0, 128, 64, 1, 1, 0, 0), 1'b1, 1'b0});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px, directed_rows[i].fixed, directed_rows[i].found);
      settle();

      run_phase(mk_cfg(3, 10, 8, 20), 0, 0, PHASE_REQUESTS, 1'b0);
      run_phase(mk_cfg(0, 0, 0, 0), 69, 0, PHASE_REQUESTS, 1'b0);
      run_phase(mk_cfg(255, 100, 511, 255), 0, 69, PHASE_REQUESTS, 1'b0);
      run_phase(mk_cfg(255, 99, 511, 0), 18, 18, PHASE_REQUESTS, 1'b1);
      run_phase(mk_cfg($urandom_range(0, 8), $urandom_range(0, 100), $urandom_range(0, 30),
                       $urandom_range(0, 255)), 0, 0, PHASE_REQUESTS, 1'b0);

      if (failures == 0)
         $display("[zebra_crossing_row_detector] OK");
      else
         $display("[zebra_crossing_row_detector] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/zcrd_pkg.sv
rtl/zcrd_pixel_eval.sv
rtl/zcrd_row_judge.sv
rtl/zebra_crossing_row_detector.sv
rtl/zcrd_checker.sv
dv/zebra_crossing_row_detector_tb.sv
